// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the trie lookup block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lpm_pkg.sv =====
// Shared constants and codes for the binary trie longest prefix match block.
`timescale 1ns / 1ps
`default_nettype none

package lpm_pkg;

   localparam int WORD_BITS         = 32;
   localparam int ROUTE_BITS        = 10;
   localparam int DEF_NODE_COUNT    = 4096;
   localparam int DEF_ADDRESS_BITS  = 32;

   localparam logic OP_INSERT   = 1'b0;
   localparam logic OP_LOOKUP   = 1'b1;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

endpackage

`default_nettype wire

// ===== design/lpm_node_mem.sv =====
// Single-port-write, single-port-read node memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lpm_node_mem #(
   parameter int DEPTH     = 4096,
   parameter int ADDR_BITS = 12,
   parameter int DATA_BITS = 35
) (
   input  wire logic                 clock,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output      logic [DATA_BITS-1:0] rd_data,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/binary_trie_longest_prefix_match.sv =====
// Top level: trie walk sequencer for route insert and longest prefix lookup.
`timescale 1ns / 1ps
`default_nettype none

// Routes live in a one-bit binary trie held in a node memory with one read and
// one write port; every trie level costs one memory access, so that port sets
// the rate. Raise start while busy is low to hand in an item. A lookup walks
// one level per cycle and goes to ST_DONE, where it shows its result, after the
// last level read. An insert walks the existing path; if the prefix reaches past
// it, the insert counts the remaining prefix bits one per cycle, checks the free
// node count, writes the last existing node and then one new node per cycle;
// else it binds the route at the last node read. A full node pool refuses
// the insert with status set and nothing written. The result stands on the
// rsp_ ports for exactly one cycle under rsp_valid; the receiver cannot
// stall it. The root is empty after reset with no clearing pass; nodes
// are allocated from a bump pointer and never freed. A /32 route does match.
module binary_trie_longest_prefix_match
   import lpm_pkg::*;
#(
   parameter int NODE_COUNT   = DEF_NODE_COUNT,
   parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire logic                  req_operation,
   input  wire logic [WORD_BITS-1:0]  req_address,
   input  wire logic [WORD_BITS-1:0]  req_mask,
   input  wire logic [ROUTE_BITS-1:0] req_route_index,
   output      logic                  rsp_valid,
   output      logic                  rsp_found,
   output      logic [ROUTE_BITS-1:0] rsp_matched_route,
   output      logic                  rsp_status
);

   localparam int NB = $clog2(NODE_COUNT);
   localparam int FB = $clog2(NODE_COUNT + 1);
   localparam int DB = $clog2(ADDRESS_BITS + 1);
   localparam int AB = ADDRESS_BITS;
   localparam int DW = 2 * NB + 1 + ROUTE_BITS;

   // node word: {child0, child1, route valid, route}
   localparam int C0_HI = DW - 1;
   localparam int C1_HI = DW - 1 - NB;
   localparam int VL_POS = ROUTE_BITS;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b000_0001,
      ST_WALK  = 7'b000_0010,
      ST_COUNT = 7'b000_0100,
      ST_CHECK = 7'b000_1000,
      ST_LINK  = 7'b001_0000,
      ST_FILL  = 7'b010_0000,
      ST_DONE  = 7'b100_0000
   } state_type;

   state_type state_ff, state_in;

   logic [FB-1:0]         next_free_ff, next_free_in;
   logic                  root_written_ff, root_written_in;

   logic                  op_ff, op_in;
   logic [AB-1:0]         addr_sh_ff, addr_sh_in;
   logic [AB-1:0]         mask_sh_ff, mask_sh_in;
   logic [ROUTE_BITS-1:0] route_ff, route_in;
   logic [NB-1:0]         cur_ff, cur_in;
   logic [DB-1:0]         depth_ff, depth_in;
   logic [DB-1:0]         count_ff, count_in;
   logic                  hit_ff, hit_in;
   logic [ROUTE_BITS-1:0] best_ff, best_in;
   logic                  status_ff, status_in;
   logic                  rd_root_ff, rd_root_in;
   logic [NB-1:0]         node_c0_ff, node_c0_in;
   logic [NB-1:0]         node_c1_ff, node_c1_in;
   logic                  node_vl_ff, node_vl_in;
   logic [ROUTE_BITS-1:0] node_rt_ff, node_rt_in;

   logic                  mem_rd_en;
   logic [NB-1:0]         mem_rd_addr;
   logic [DW-1:0]         mem_rd_data;
   logic                  mem_wr_en;
   logic [NB-1:0]         mem_wr_addr;
   logic [DW-1:0]         mem_wr_data;

   logic [DW-1:0]         node_rd;
   logic [NB-1:0]         rd_c0;
   logic [NB-1:0]         rd_c1;
   logic                  rd_vl;
   logic [ROUTE_BITS-1:0] rd_rt;
   logic                  cur_bit;
   logic                  mask_msb;
   logic [NB-1:0]         nxt;
   logic [NB-1:0]         fresh_node;
   logic [NB-1:0]         after_new;
   logic                  last_fill;

   lpm_node_mem #(
      .DEPTH     (NODE_COUNT),
      .ADDR_BITS (NB),
      .DATA_BITS (DW)
   ) u_node_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // an unwritten root reads as empty
   assign node_rd    = (rd_root_ff && !root_written_ff) ? '0 : mem_rd_data;
   assign rd_c0      = node_rd[C0_HI -: NB];
   assign rd_c1      = node_rd[C1_HI -: NB];
   assign rd_vl      = node_rd[VL_POS];
   assign rd_rt      = node_rd[ROUTE_BITS-1:0];
   assign cur_bit    = addr_sh_ff[AB-1];
   assign mask_msb   = mask_sh_ff[AB-1];
   assign nxt        = cur_bit ? rd_c1 : rd_c0;
   assign fresh_node = next_free_ff[NB-1:0];
   assign after_new  = NB'(next_free_ff + FB'(1));
   assign last_fill  = (count_ff == DB'(1));

   always_comb begin
      state_in        = state_ff;
      next_free_in    = next_free_ff;
      root_written_in = root_written_ff;
      op_in           = op_ff;
      addr_sh_in      = addr_sh_ff;
      mask_sh_in      = mask_sh_ff;
      route_in        = route_ff;
      cur_in          = cur_ff;
      depth_in        = depth_ff;
      count_in        = count_ff;
      hit_in          = hit_ff;
      best_in         = best_ff;
      status_in       = status_ff;
      rd_root_in      = rd_root_ff;
      node_c0_in      = node_c0_ff;
      node_c1_in      = node_c1_ff;
      node_vl_in      = node_vl_ff;
      node_rt_in      = node_rt_ff;
      mem_rd_en       = 1'b0;
      mem_rd_addr     = '0;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = '0;
      mem_wr_data     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in       = req_operation;
               addr_sh_in  = req_address[AB-1:0];
               mask_sh_in  = req_mask[AB-1:0];
               route_in    = req_route_index;
               cur_in      = '0;
               depth_in    = '0;
               count_in    = '0;
               hit_in      = 1'b0;
               best_in     = '0;
               status_in   = STATUS_DONE;
               mem_rd_en   = 1'b1;
               mem_rd_addr = '0;
               rd_root_in  = 1'b1;
               state_in    = ST_WALK;
            end
         end

         ST_WALK: begin
            node_c0_in = rd_c0;
            node_c1_in = rd_c1;
            node_vl_in = rd_vl;
            node_rt_in = rd_rt;
            if (op_ff == OP_LOOKUP) begin
               if (rd_vl) begin
                  hit_in  = 1'b1;
                  best_in = rd_rt;
               end
               if (depth_ff == DB'(AB) || nxt == '0) begin
                  state_in = ST_DONE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = nxt;
                  rd_root_in  = 1'b0;
                  cur_in      = nxt;
                  depth_in    = depth_ff + DB'(1);
                  addr_sh_in  = {addr_sh_ff[AB-2:0], 1'b0};
               end
            end else begin
               if (!mask_msb) begin
                  // whole path exists: bind route at this node
                  state_in = ST_LINK;
               end else if (nxt == '0) begin
                  // hold address at the first missing level
                  state_in = ST_COUNT;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = nxt;
                  rd_root_in  = 1'b0;
                  cur_in      = nxt;
                  depth_in    = depth_ff + DB'(1);
                  addr_sh_in  = {addr_sh_ff[AB-2:0], 1'b0};
                  mask_sh_in  = {mask_sh_ff[AB-2:0], 1'b0};
               end
            end
         end

         ST_COUNT: begin
            if (mask_msb) begin
               count_in   = count_ff + DB'(1);
               mask_sh_in = {mask_sh_ff[AB-2:0], 1'b0};
            end else begin
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (FB'(count_ff) > FB'(NODE_COUNT) - next_free_ff) begin
               status_in = STATUS_FULL;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_LINK;
            end
         end

         ST_LINK: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cur_ff;
            if (cur_ff == '0) begin
               root_written_in = 1'b1;
            end
            if (count_ff == '0) begin
               mem_wr_data = {node_c0_ff, node_c1_ff, 1'b1, route_ff};
               state_in    = ST_DONE;
            end else begin
               mem_wr_data = {cur_bit ? node_c0_ff : fresh_node,
                              cur_bit ? fresh_node : node_c1_ff,
                              node_vl_ff, node_rt_ff};
               addr_sh_in  = {addr_sh_ff[AB-2:0], 1'b0};
               state_in    = ST_FILL;
            end
         end

         ST_FILL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = fresh_node;
            if (last_fill) begin
               mem_wr_data = {{NB{1'b0}}, {NB{1'b0}}, 1'b1, route_ff};
               state_in    = ST_DONE;
            end else begin
               mem_wr_data = {cur_bit ? {NB{1'b0}} : after_new,
                              cur_bit ? after_new : {NB{1'b0}},
                              1'b0, {ROUTE_BITS{1'b0}}};
            end
            next_free_in = next_free_ff + FB'(1);
            count_in     = count_ff - DB'(1);
            addr_sh_in   = {addr_sh_ff[AB-2:0], 1'b0};
         end

         ST_DONE: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         next_free_ff    <= FB'(1);
         root_written_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         next_free_ff    <= next_free_in;
         root_written_ff <= root_written_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      addr_sh_ff <= addr_sh_in;
      mask_sh_ff <= mask_sh_in;
      route_ff   <= route_in;
      cur_ff     <= cur_in;
      depth_ff   <= depth_in;
      count_ff   <= count_in;
      hit_ff     <= hit_in;
      best_ff    <= best_in;
      status_ff  <= status_in;
      rd_root_ff <= rd_root_in;
      node_c0_ff <= node_c0_in;
      node_c1_ff <= node_c1_in;
      node_vl_ff <= node_vl_in;
      node_rt_ff <= node_rt_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = (state_ff == ST_DONE);
   assign rsp_found         = hit_ff;
   assign rsp_matched_route = best_ff;
   assign rsp_status        = status_ff;

endmodule

`default_nettype wire

// ===== design/lpm_checker.sv =====
// Port-level checker for the trie lookup block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lpm_checker
   import lpm_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_found,
   input wire logic [ROUTE_BITS-1:0] rsp_matched_route,
   input wire logic                  rsp_status
);

   `ASSERT_NEXT_CYCLE(a_accept_busy, clock, reset, start && !busy, busy, "accepted item did not raise busy")
   `ASSERT_SAME_CYCLE(a_rsp_in_busy, clock, reset, rsp_valid, busy, "result shown while idle")
   `ASSERT_NEXT_CYCLE(a_rsp_ends, clock, reset, rsp_valid, !busy && !rsp_valid, "result not followed by idle")
   `ASSERT_SAME_CYCLE(a_found_ok, clock, reset, rsp_valid && rsp_found, rsp_status == STATUS_DONE, "match reported with full status")
   `ASSERT_SAME_CYCLE(a_miss_zero, clock, reset, rsp_valid && !rsp_found, rsp_matched_route == '0, "route not zero without match")

endmodule

bind binary_trie_longest_prefix_match lpm_checker u_lpm_checker (.*);

`default_nettype wire
